// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is low.
`define ASSERT_RUN(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// File: src/lruc_pkg.sv
`default_nettype none

package lruc_pkg;

   // Storage geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // Field widths
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   // Capacity after reset: 16, or the whole store when it is smaller
   localparam int CAP_RESET = (ENTRIES < 16) ? ENTRIES : 16;

   // Operation codes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_GET,
      ST_REMOVE,
      ST_EVICT,
      ST_INSERT,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic match_done;
      logic get_done;
      logic remove_hit;
      logic evict;
      logic insert;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic op_put;
      logic evict_need;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

// File: src/lruc_ram.sv
`default_nettype none

module lruc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/lruc_ctrl.sv
`default_nettype none

module lruc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire lruc_pkg::status_type status,
   output      lruc_pkg::cmd_type    cmd,
   output      logic                req_stall
);

   import lruc_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match_done = 1'b1;
            state_in       = status.op_put ? ST_REMOVE : ST_GET;
         end
         ST_GET: begin
            cmd.get_done = 1'b1;
            state_in     = ST_DONE;
         end
         ST_REMOVE: begin
            cmd.remove_hit = 1'b1;
            state_in       = ST_EVICT;
         end
         ST_EVICT: begin
            cmd.evict = status.evict_need;
            state_in  = ST_INSERT;
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: src/lruc_datapath.sv
`default_nettype none

module lruc_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lruc_pkg::cmd_type             cmd,
   output      lruc_pkg::status_type          status,
   input  wire logic                          req_operation,
   input  wire logic signed [lruc_pkg::KEY_W-1:0] req_lookup_key,
   input  wire logic signed [lruc_pkg::VAL_W-1:0] req_store_value,
   input  wire logic                          csr_wr_en,
   input  wire logic [lruc_pkg::CAP_W-1:0]    csr_wr_data,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic                          rsp_hit,
   output      logic signed [lruc_pkg::VAL_W-1:0] rsp_read_value,
   output      logic                          rsp_evicted
);

   import lruc_pkg::*;

   // Captured transaction
   logic             op_ff;
   logic [KEY_W-1:0] key_req_ff;
   logic [VAL_W-1:0] val_req_ff;

   // Entry state
   logic             valid_ff [ENTRIES];
   logic             valid_in [ENTRIES];
   logic [KEY_W-1:0] key_ff   [ENTRIES];
   logic [KEY_W-1:0] key_in   [ENTRIES];
   logic [IDX_W-1:0] rank_ff  [ENTRIES];
   logic [IDX_W-1:0] rank_in  [ENTRIES];
   logic [CNT_W-1:0] occ_ff;
   logic [CNT_W-1:0] occ_in;
   logic [CNT_W-1:0] cap_ff;
   logic [CNT_W-1:0] cap_in;

   // Lookup results
   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic             evicted_ff;
   logic [VAL_W-1:0] get_value_ff;

   // Output register
   logic             rsp_valid_ff;
   logic             rsp_hit_ff;
   logic [VAL_W-1:0] rsp_value_ff;
   logic             rsp_evicted_ff;

   // Combinational helpers
   logic             match_any;
   logic [IDX_W-1:0] match_idx;
   logic [IDX_W-1:0] hit_rank;
   logic             old_found;
   logic [IDX_W-1:0] old_idx;
   logic [IDX_W-1:0] old_rank;
   logic             slot_found;
   logic [IDX_W-1:0] slot_idx;
   logic [VAL_W-1:0] ram_rd_data;
   logic             rsp_free;

   // Parallel key compare; valid keys are unique so the match is one-hot
   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (valid_ff[i] && (key_ff[i] == key_req_ff)) begin
            match_any = 1'b1;
            match_idx = match_idx | IDX_W'(i);
         end
      end
   end

   // Least recent entry carries rank occupancy-1
   assign old_rank = IDX_W'(occ_ff - CNT_W'(1));

   always_comb begin
      old_found = 1'b0;
      old_idx   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (valid_ff[i] && (rank_ff[i] == old_rank)) begin
            old_found = 1'b1;
            old_idx   = old_idx | IDX_W'(i);
         end
      end
   end

   // Lowest free slot
   always_comb begin
      slot_found = 1'b0;
      slot_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            slot_found = 1'b1;
            slot_idx   = IDX_W'(i);
         end
      end
   end

   assign hit_rank = rank_ff[hit_idx_ff];

   // Entry state update
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      rank_in  = rank_ff;
      occ_in   = occ_ff;
      // get hit: entries more recent than the hit age by one
      if (cmd.get_done && hit_ff) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
         rank_in[hit_idx_ff] = '0;
      end
      // put on existing key: drop the old entry and close the rank gap
      if (cmd.remove_hit && hit_ff) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_ff[i] && (rank_ff[i] > hit_rank)) begin
               rank_in[i] = rank_ff[i] - IDX_W'(1);
            end
         end
         valid_in[hit_idx_ff] = 1'b0;
         rank_in[hit_idx_ff]  = '0;
         occ_in               = occ_ff - CNT_W'(1);
      end
      // eviction: oldest has the top rank, no gap to close
      if (cmd.evict && old_found) begin
         valid_in[old_idx] = 1'b0;
         rank_in[old_idx]  = '0;
         occ_in            = occ_ff - CNT_W'(1);
      end
      // insert as most recent
      if (cmd.insert && slot_found) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
         valid_in[slot_idx] = 1'b1;
         key_in[slot_idx]   = key_req_ff;
         rank_in[slot_idx]  = '0;
         occ_in             = occ_ff + CNT_W'(1);
      end
   end

   // Capacity write saturates to 1..ENTRIES
   always_comb begin
      cap_in = cap_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            cap_in = CNT_W'(1);
         end else if (32'(csr_wr_data) > ENTRIES) begin
            cap_in = CNT_W'(ENTRIES);
         end else begin
            cap_in = CNT_W'(csr_wr_data);
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '{default: 1'b0};
         rank_ff      <= '{default: '0};
         occ_ff       <= '0;
         cap_ff       <= CNT_W'(CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         occ_ff   <= occ_in;
         cap_ff   <= cap_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (cmd.capture) begin
         op_ff      <= req_operation;
         key_req_ff <= req_lookup_key;
         val_req_ff <= req_store_value;
         evicted_ff <= 1'b0;
      end
      if (cmd.match_done) begin
         hit_ff     <= match_any;
         hit_idx_ff <= match_idx;
      end
      if (cmd.evict) begin
         evicted_ff <= 1'b1;
      end
      if (cmd.get_done) begin
         get_value_ff <= hit_ff ? ram_rd_data : '1;
      end
      if (cmd.load_rsp) begin
         rsp_hit_ff     <= hit_ff;
         rsp_value_ff   <= (op_ff == OP_PUT) ? '0 : get_value_ff;
         rsp_evicted_ff <= evicted_ff;
      end
   end

   // Value store: read at the matching entry, written at the insert slot
   lruc_ram #(
      .WIDTH (VAL_W),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.insert && slot_found),
      .wr_addr (slot_idx),
      .wr_data (val_req_ff),
      .rd_addr (match_idx),
      .rd_data (ram_rd_data)
   );

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign status.op_put     = (op_ff == OP_PUT);
   assign status.evict_need = (occ_ff >= cap_ff) && (occ_ff != '0);
   assign status.rsp_free   = rsp_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

endmodule

`default_nettype wire

// File: src/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// Request channel (req_*): operation (0 get, 1 put), lookup_key, store_value.
// A transaction is taken on a clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): hit, read_value, evicted; one response per request,
// in order, taken on an edge with rsp_valid high and rsp_stall low.
// csr_wr_en/csr_wr_data set the capacity, saturated to 1..16; write only when idle.
// One request is in work at a time; the controller steps it through compare,
// value read or remove/evict/insert, and a done step that loads the response.
// The response sits in an output register; a new request is taken while it
// waits, and if the receiver still stalls when the next one finishes,
// that one holds in its last step and req_stall stays high.
// Reset (synchronous, active high) empties the cache, sets capacity to 16
// and drops any pending response. No clearing pass is needed after reset.
`default_nettype none

module lru_key_value_cache (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic                              req_operation,
   input  wire logic signed [lruc_pkg::KEY_W-1:0] req_lookup_key,
   input  wire logic signed [lruc_pkg::VAL_W-1:0] req_store_value,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic                              rsp_hit,
   output      logic signed [lruc_pkg::VAL_W-1:0] rsp_read_value,
   output      logic                              rsp_evicted,
   input  wire logic                              csr_wr_en,
   input  wire logic [lruc_pkg::CAP_W-1:0]        csr_wr_data
);

   import lruc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer
   lruc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // Entry store, rank logic and output register
   lruc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_lookup_key  (req_lookup_key),
      .req_store_value (req_store_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted)
   );

endmodule

`default_nettype wire

// File: src/lruc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module lruc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic                              rsp_hit,
   input wire logic signed [lruc_pkg::VAL_W-1:0] rsp_read_value,
   input wire logic                              rsp_evicted
);

   logic req_fire;
   logic rsp_is_put;

   assign req_fire   = req_valid && !req_stall;
   assign rsp_is_put = (rsp_read_value == '0);

   // Reset drops any pending response
   `ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "response valid after reset")

   // One request in work: the request side closes right after a transaction
   `ASSERT_RUN(a_busy_after_req, clock, reset, req_fire |=> req_stall, "request taken while busy")

   // Eviction is reported only by a put, whose read value is zero
   `ASSERT_RUN(a_evict_is_put, clock, reset, (rsp_valid && rsp_evicted) |-> rsp_is_put, "evicted on get")

   // A miss reads as -1 (get) or 0 (put)
   `ASSERT_RUN(a_miss_value, clock, reset, (rsp_valid && !rsp_hit) |-> (rsp_is_put || (rsp_read_value == -32'sd1)), "bad miss value")

   // Stalled response holds
   `ASSERT_RUN(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_read_value)), "response dropped under stall")

endmodule

bind lru_key_value_cache lruc_checker u_checker (.*);

`default_nettype wire
